>>> design/cvw_pkg.sv
package cvw_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int SQRT_STEPS = 33;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONE_SECANT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONE_TANGENT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INWARD_CONE = 3'd4;

   localparam logic signed [55:0] SAT_MAX = 56'sd2147483647;
   localparam logic signed [55:0] SAT_MIN = -56'sd2147483648;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
   } cvw_req_type;

   typedef struct packed {
      logic signed [31:0] warped_x;
      logic signed [31:0] warped_y;
      logic signed [31:0] warped_z;
      logic               clipped;
   } cvw_rsp_type;

   // payload that rides alongside the root pipeline
   typedef struct packed {
      logic signed [31:0] vert_z;
      logic signed [31:0] warped_x;
      logic signed [31:0] warped_y;
      logic               clip_xy;
   } cvw_side_type;

   // one restoring square root step: partial remainder, root so far, radicand left
   typedef struct packed {
      logic [33:0] rem;
      logic [32:0] root;
      logic [65:0] rad;
   } cvw_sqrt_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clip;
   } cvw_sat_type;

   function automatic cvw_sat_type cvw_saturate(input logic signed [55:0] v);
      cvw_sat_type res;
      if (v > SAT_MAX) begin
         res.value = 32'sh7fffffff;
         res.clip = 1'b1;
      end else if (v < SAT_MIN) begin
         res.value = 32'sh80000000;
         res.clip = 1'b1;
      end else begin
         res.value = v[31:0];
         res.clip = 1'b0;
      end
      return res;
   endfunction

endpackage

>>> design/cvw_front.sv
module cvw_front import cvw_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  cvw_req_type        in_data,
   input  logic signed [31:0] origin_x,
   input  logic signed [31:0] origin_y,
   input  logic [19:0]        cone_secant,
   output logic               out_valid,
   output logic [65:0]        out_sum,
   output logic signed [53:0] out_rx,
   output logic signed [53:0] out_ry,
   output logic signed [31:0] out_vz
);

   localparam logic signed [53:0] HALF = 54'sd1 <<< (FRACTION_BITS - 1);

   // stage 1: offsets from the centre
   logic               v1_ff;
   logic signed [32:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [31:0] vz1_ff;

   // stage 2: squares and secant products
   logic               v2_ff;
   logic [32:0]        ax, ay;
   logic [65:0]        sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic signed [53:0] px_ff, py_ff, px_in, py_in;
   logic signed [31:0] vz2_ff;

   // stage 3: radius squared and rounded scaled offsets
   logic               v3_ff;
   logic [65:0]        sum_ff, sum_in;
   logic signed [53:0] rx_ff, ry_ff, rx_in, ry_in;
   logic signed [31:0] vz3_ff;

   always_comb begin
      dx_in = 33'(in_data.vert_x) - 33'(origin_x);
      dy_in = 33'(in_data.vert_y) - 33'(origin_y);
   end

   always_comb begin
      ax = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      ay = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      sqx_in = 66'(ax) * 66'(ax);
      sqy_in = 66'(ay) * 66'(ay);
      px_in = 54'(dx_ff) * $signed({34'd0, cone_secant});
      py_in = 54'(dy_ff) * $signed({34'd0, cone_secant});
   end

   // ties away from zero: negative values take one less than half
   always_comb begin
      sum_in = sqx_ff + sqy_ff;
      rx_in = (px_ff + (px_ff[53] ? HALF - 54'sd1 : HALF)) >>> FRACTION_BITS;
      ry_in = (py_ff + (py_ff[53] ? HALF - 54'sd1 : HALF)) >>> FRACTION_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         vz1_ff <= in_data.vert_z;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         px_ff <= px_in;
         py_ff <= py_in;
         vz2_ff <= vz1_ff;
         sum_ff <= sum_in;
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         vz3_ff <= vz2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_sum = sum_ff;
   assign out_rx = rx_ff;
   assign out_ry = ry_ff;
   assign out_vz = vz3_ff;

endmodule

>>> design/cvw_root_step.sv
module cvw_root_step import cvw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  cvw_sqrt_type in_sqrt,
   input  cvw_side_type in_side,
   output logic         out_valid,
   output cvw_sqrt_type out_sqrt,
   output cvw_side_type out_side
);

   logic         valid_ff;
   cvw_sqrt_type sqrt_ff, sqrt_in;
   cvw_side_type side_ff;
   logic [35:0]  rem_cat, trial, diff;
   logic         fits;

   always_comb begin
      rem_cat = {in_sqrt.rem, in_sqrt.rad[65:64]};
      trial = {1'b0, in_sqrt.root, 2'b01};
      fits = rem_cat >= trial;
      diff = rem_cat - trial;
      sqrt_in.rem = fits ? diff[33:0] : rem_cat[33:0];
      sqrt_in.root = {in_sqrt.root[31:0], fits};
      sqrt_in.rad = {in_sqrt.rad[63:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqrt_ff <= sqrt_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_sqrt = sqrt_ff;
   assign out_side = side_ff;

endmodule

>>> design/cvw_isqrt.sv
module cvw_isqrt import cvw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [65:0]  in_rad,
   input  cvw_side_type in_side,
   output logic         out_valid,
   output logic [32:0]  out_root,
   output cvw_side_type out_side
);

   logic         valid [0:SQRT_STEPS];
   cvw_sqrt_type sqrt  [0:SQRT_STEPS];
   cvw_side_type side  [0:SQRT_STEPS];

   always_comb begin
      valid[0] = in_valid;
      sqrt[0].rem = '0;
      sqrt[0].root = '0;
      sqrt[0].rad = in_rad;
      side[0] = in_side;
   end

   // one root bit per stage, most significant pair first
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      cvw_root_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid[k]),
         .in_sqrt   (sqrt[k]),
         .in_side   (side[k]),
         .out_valid (valid[k+1]),
         .out_sqrt  (sqrt[k+1]),
         .out_side  (side[k+1])
      );
   end

   assign out_valid = valid[SQRT_STEPS];
   assign out_root = sqrt[SQRT_STEPS].root;
   assign out_side = side[SQRT_STEPS];

endmodule

>>> design/conical_vertex_warp.sv
// Conical vertex warp: streams mesh vertices through a cone transform.
// Input channel req_*: one vertex per beat (x, y, z signed fixed point),
// taken when req_valid is high and req_stall low. Result channel rsp_*:
// one warped vertex per input beat, in order, with a clipped flag set
// when any coordinate saturated to the signed 32-bit range.
// Configuration: csr_* writes one register per beat (csr_ready is always
// high); index 0 centre x, 1 centre y, 2 secant, 3 tangent, 4 inward mode.
// The user must write registers only while the pipeline is empty (not enforced).
// The pipeline has 39 register stages: three front stages (offset,
// square/scale, sum/round), 33 stages of the restoring square root (one
// root bit each) and three back stages (tangent product, rounding, z
// update with saturation into the output register).
// Throughput is one vertex per cycle. The pipeline moves as a whole: while
// rsp_valid is high and rsp_stall is high every stage holds and req_stall
// is raised, so nothing is lost or repeated.
// Reset clears all valid bits and sets the registers to centre 0, secant
// 1.0, tangent 0, outward mode.
module conical_vertex_warp import cvw_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  cvw_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cvw_rsp_type                rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_data
);

   localparam logic [53:0] HALF = 54'd1 << (FRACTION_BITS - 1);

   logic signed [31:0] origin_x_ff, origin_x_in;
   logic signed [31:0] origin_y_ff, origin_y_in;
   logic [19:0]        cone_secant_ff, cone_secant_in;
   logic [19:0]        cone_tangent_ff, cone_tangent_in;
   logic               inward_cone_ff, inward_cone_in;

   logic               en;

   logic               front_valid;
   logic [65:0]        front_sum;
   logic signed [53:0] front_rx, front_ry;
   logic signed [31:0] front_vz;
   cvw_side_type       side_in;
   cvw_sat_type        sat_x, sat_y, sat_z;

   logic               root_valid;
   logic [32:0]        root;
   cvw_side_type       root_side;

   logic               vm_ff;
   logic [52:0]        prod_ff, prod_in;
   cvw_side_type       side_m_ff;

   logic               vh_ff;
   logic [53:0]        h_ff, h_in;
   cvw_side_type       side_h_ff;

   logic signed [55:0] z_full;
   logic               rsp_valid_ff;
   cvw_rsp_type        rsp_data_ff, rsp_data_in;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      cone_secant_in = cone_secant_ff;
      cone_tangent_in = cone_tangent_ff;
      inward_cone_in = inward_cone_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:     origin_x_in = csr_data;
            CSR_ORIGIN_Y:     origin_y_in = csr_data;
            CSR_CONE_SECANT:  cone_secant_in = csr_data[19:0];
            CSR_CONE_TANGENT: cone_tangent_in = csr_data[19:0];
            CSR_INWARD_CONE:  inward_cone_in = csr_data[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         cone_secant_ff <= 20'(64'd1 << FRACTION_BITS);
         cone_tangent_ff <= '0;
         inward_cone_ff <= 1'b0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         cone_secant_ff <= cone_secant_in;
         cone_tangent_ff <= cone_tangent_in;
         inward_cone_ff <= inward_cone_in;
      end
   end

   // whole pipeline advances unless the output register is held
   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   cvw_front #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .in_data     (req_data),
      .origin_x    (origin_x_ff),
      .origin_y    (origin_y_ff),
      .cone_secant (cone_secant_ff),
      .out_valid   (front_valid),
      .out_sum     (front_sum),
      .out_rx      (front_rx),
      .out_ry      (front_ry),
      .out_vz      (front_vz)
   );

   // centre added back and x/y saturated on entry to the root pipeline
   always_comb begin
      sat_x = cvw_saturate(56'(front_rx) + 56'(origin_x_ff));
      sat_y = cvw_saturate(56'(front_ry) + 56'(origin_y_ff));
      side_in.vert_z = front_vz;
      side_in.warped_x = sat_x.value;
      side_in.warped_y = sat_y.value;
      side_in.clip_xy = sat_x.clip | sat_y.clip;
   end

   cvw_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_rad    (front_sum),
      .in_side   (side_in),
      .out_valid (root_valid),
      .out_root  (root),
      .out_side  (root_side)
   );

   // back end: tangent product, rounding, z update
   always_comb begin
      prod_in = 53'(root) * 53'(cone_tangent_ff);
      h_in = ({1'b0, prod_ff} + HALF) >> FRACTION_BITS;
      z_full = inward_cone_ff ? 56'(side_h_ff.vert_z) - 56'(h_ff)
                              : 56'(side_h_ff.vert_z) + 56'(h_ff);
      sat_z = cvw_saturate(z_full);
      rsp_data_in.warped_x = side_h_ff.warped_x;
      rsp_data_in.warped_y = side_h_ff.warped_y;
      rsp_data_in.warped_z = sat_z.value;
      rsp_data_in.clipped = side_h_ff.clip_xy | sat_z.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
         vh_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vm_ff <= root_valid;
         vh_ff <= vm_ff;
         rsp_valid_ff <= vh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         side_m_ff <= root_side;
         h_ff <= h_in;
         side_h_ff <= side_m_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
